// ----- hdl/smd_pkg.sv -----
// smd_pkg: shared types and constants of the serial message deframer
// no dependencies; used by the interfaces, smd_parser, smd_drain and the top level

package smd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned OUT_LEN_W = 6;   // payload_length field
   localparam int unsigned OUT_IDX_W = 5;   // byte_index field
   localparam int unsigned LEN_W_MAX = 7;   // holds any length up to the largest buffer

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA4;

   // parser states, one-hot
   typedef enum logic [4:0] {
      ST_HUNT = 5'b00001,
      ST_LEN  = 5'b00010,
      ST_ID   = 5'b00100,
      ST_DATA = 5'b01000,
      ST_CSUM = 5'b10000
   } parse_state_type;

   // frame handoff from parser to drain
   typedef struct packed {
      logic                  valid;
      logic [BYTE_W-1:0]     msg_id;
      logic [LEN_W_MAX-1:0]  length;
      logic                  bad;
   } frame_start_type;

endpackage

// ----- hdl/smd_if.sv -----
// smd_if: valid/ready channel interfaces for received bytes and result items
// depends on smd_pkg

interface smd_req_if;
   logic                       valid;
   logic                       ready;
   logic [smd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [smd_pkg::BYTE_W-1:0]    msg_id;
   logic [smd_pkg::OUT_LEN_W-1:0] payload_length;
   logic [smd_pkg::OUT_IDX_W-1:0] byte_index;
   logic [smd_pkg::BYTE_W-1:0]    payload_byte;
   logic                          has_data;
   logic                          frame_status;
   logic                          last_of_frame;

   modport source (output valid, output msg_id, output payload_length,
                   output byte_index, output payload_byte, output has_data,
                   output frame_status, output last_of_frame, input ready);
   modport sink   (input valid, input msg_id, input payload_length,
                   input byte_index, input payload_byte, input has_data,
                   input frame_status, input last_of_frame, output ready);
endinterface

// ----- hdl/smd_payload_ram.sv -----
// smd_payload_ram: payload buffer, one write port and one registered read port
// no package dependencies

module smd_payload_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/smd_parser.sv -----
// smd_parser: sync hunt, header capture, checksum and payload write into the buffer
// depends on smd_pkg and smd_if

module smd_parser #(
   parameter int unsigned MAX_PAYLOAD = 32,
   parameter int unsigned AW          = 5,
   parameter int unsigned LW          = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   smd_req_if.sink                req,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   drain_busy,
   output logic                   ram_wr_en,
   output logic [AW-1:0]          ram_wr_addr,
   output logic [7:0]             ram_wr_data,
   output smd_pkg::frame_start_type start
);

   smd_pkg::parse_state_type state_ff, state_in;
   logic [7:0]    sync_ff;
   logic [7:0]    csum_ff, csum_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    id_ff, id_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          take;
   logic          too_long;
   logic          data_last;

   // payload and checksum bytes wait while the previous frame is still draining
   assign req.ready = !(drain_busy &&
                        (state_ff == smd_pkg::ST_DATA || state_ff == smd_pkg::ST_CSUM));
   assign take      = req.valid && req.ready;
   assign too_long  = ({1'b0, req.rx_byte} > 9'(MAX_PAYLOAD));
   assign data_last = ((LW)'(cnt_ff) + (LW)'(1)) == len_ff;

   always_comb begin
      state_in     = state_ff;
      csum_in      = csum_ff;
      len_in       = len_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      ram_wr_en    = 1'b0;
      start        = '0;
      start.msg_id = id_ff;
      start.length = (smd_pkg::LEN_W_MAX)'(len_ff);
      start.bad    = (csum_ff != req.rx_byte);
      if (take) begin
         unique case (state_ff)
            smd_pkg::ST_HUNT: begin
               if (req.rx_byte == sync_ff) begin
                  csum_in  = req.rx_byte;
                  state_in = smd_pkg::ST_LEN;
               end
            end
            smd_pkg::ST_LEN: begin
               if (too_long) begin
                  state_in = smd_pkg::ST_HUNT;
               end else begin
                  len_in   = req.rx_byte[LW-1:0];
                  csum_in  = csum_ff ^ req.rx_byte;
                  state_in = smd_pkg::ST_ID;
               end
            end
            smd_pkg::ST_ID: begin
               id_in    = req.rx_byte;
               csum_in  = csum_ff ^ req.rx_byte;
               cnt_in   = '0;
               state_in = (len_ff == '0) ? smd_pkg::ST_CSUM : smd_pkg::ST_DATA;
            end
            smd_pkg::ST_DATA: begin
               ram_wr_en = 1'b1;
               csum_in   = csum_ff ^ req.rx_byte;
               cnt_in    = cnt_ff + AW'(1);
               if (data_last) begin
                  state_in = smd_pkg::ST_CSUM;
               end
            end
            smd_pkg::ST_CSUM: begin
               start.valid = 1'b1;
               state_in    = smd_pkg::ST_HUNT;
            end
            default: begin
               state_in = smd_pkg::ST_HUNT;
            end
         endcase
      end
   end

   assign ram_wr_addr = cnt_ff;
   assign ram_wr_data = req.rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smd_pkg::ST_HUNT;
         sync_ff  <= smd_pkg::SYNC_RESET;
         csum_ff  <= '0;
         len_ff   <= '0;
         id_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         csum_ff  <= csum_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
      end
   end

   // no buffer write while an earlier frame is still being read out
   a_no_write_while_draining: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !drain_busy)
      else $error("payload write during drain");

   // write index never passes the captured length
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smd_pkg::ST_DATA) |-> ((LW)'(cnt_ff) < len_ff))
      else $error("payload index beyond frame length");

endmodule

// ----- hdl/smd_drain.sv -----
// smd_drain: walks the payload buffer after a frame ends and drives the result items
// depends on smd_pkg and smd_if

module smd_drain #(
   parameter int unsigned AW = 5,
   parameter int unsigned LW = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smd_pkg::frame_start_type start,
   smd_rsp_if.source                rsp,
   output logic                     busy,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  logic [7:0]               rd_data
);

   logic          out_valid_ff, out_valid_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    id_ff, id_in;
   logic          bad_ff, bad_in;
   logic          has_ff, has_in;
   logic          last_ff, last_in;
   logic          taken;
   logic [LW-1:0] start_len;

   assign taken     = out_valid_ff && rsp.ready;
   assign start_len = start.length[LW-1:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      id_in        = id_ff;
      bad_in       = bad_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff + AW'(1);
      if (start.valid) begin
         out_valid_in = 1'b1;
         idx_in       = '0;
         len_in       = start_len;
         id_in        = start.msg_id;
         bad_in       = start.bad;
         has_in       = (start_len != '0);
         last_in      = (start_len <= (LW)'(1));
         rd_en        = (start_len != '0);
         rd_addr      = '0;
      end else if (taken) begin
         if (last_ff) begin
            out_valid_in = 1'b0;
         end else begin
            // next entry is read as this one leaves; read data holds under stall
            idx_in  = idx_ff + AW'(1);
            rd_en   = 1'b1;
            last_in = ((LW + 1)'(idx_ff) + (LW + 1)'(2)) == (LW + 1)'(len_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      id_ff   <= id_in;
      bad_ff  <= bad_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign busy               = out_valid_ff;
   assign rsp.valid          = out_valid_ff;
   assign rsp.msg_id         = id_ff;
   assign rsp.payload_length = (smd_pkg::OUT_LEN_W)'(len_ff);
   assign rsp.byte_index     = (smd_pkg::OUT_IDX_W)'(idx_ff);
   assign rsp.payload_byte   = has_ff ? rd_data : 8'h00;
   assign rsp.has_data       = has_ff;
   assign rsp.frame_status   = bad_ff;
   assign rsp.last_of_frame  = last_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> !out_valid_ff)
      else $error("frame handed over while results pending");

   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |=> out_valid_ff)
      else $error("frame ended without a last item");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (taken && last_ff) |=> !out_valid_ff)
      else $error("item after last of frame");

endmodule

// ----- hdl/serial_message_deframer_unit.sv -----
// serial_message_deframer_unit: top level of the serial message deframer
// depends on smd_pkg, smd_if, smd_parser, smd_drain and smd_payload_ram
//
//   channel   direction  kind           carries
//   req_in    in         valid/ready    rx_byte, one received byte per item
//   rsp_out   out        valid/ready    one item per payload byte, or one for an empty frame
//   csr_*     in         write only     sync_value register, reset 0xA4
//
// a byte is taken every cycle while the parser is hunting or reading the header
// after the checksum byte the drain gives one result item per cycle unless rsp_out stalls,
//   via the registered read port of the payload buffer, 1 to MAX_PAYLOAD items per frame
// payload and checksum bytes of the next frame stall while an earlier frame still drains
// a stall on rsp_out holds the item and the buffer read data in place
// synchronous reset clears control state; buffer contents stay undefined until written

module serial_message_deframer_unit #(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic      clock,
   input  logic      reset,
   smd_req_if.sink   req_in,
   smd_rsp_if.source rsp_out,
   input  logic      csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // buffer address and length widths follow the buffer depth
   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);

   smd_pkg::frame_start_type start;
   logic          drain_busy;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   // byte side: sync hunt, header, checksum, payload writes
   smd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW),
      .LW          (LW)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req         (req_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .drain_busy  (drain_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .start       (start)
   );

   // payload buffer, written by the parser and read by the drain
   smd_payload_ram #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result side: walks the buffer once per completed frame
   smd_drain #(
      .AW (AW),
      .LW (LW)
   ) u_drain (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .rsp     (rsp_out),
      .busy    (drain_busy),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
